@@ hw/rtl/cls_pkg.sv @@
// Shared types, codes and constants of the cellular link supervisor.
package cls_pkg;

  // Link phases
  localparam logic [2:0] PH_OFF       = 3'd0;
  localparam logic [2:0] PH_SETTLING  = 3'd1;
  localparam logic [2:0] PH_INIT      = 3'd2;
  localparam logic [2:0] PH_NETWORK   = 3'd3;
  localparam logic [2:0] PH_ATTACHING = 3'd4;
  localparam logic [2:0] PH_READY     = 3'd5;
  localparam logic [2:0] PH_BACKOFF   = 3'd6;

  // Item kinds carried in tuser
  localparam logic [2:0] MODE_TICK      = 3'd0;
  localparam logic [2:0] MODE_START     = 3'd1;
  localparam logic [2:0] MODE_XPORT     = 3'd2;
  localparam logic [2:0] MODE_LOST      = 3'd3;
  localparam logic [2:0] MODE_CONNECTED = 3'd4;
  localparam logic [2:0] MODE_ACQUIRE   = 3'd5;
  localparam logic [2:0] MODE_RELEASE   = 3'd6;

  // Modem commands
  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_PROBE     = 3'd1;
  localparam logic [2:0] CMD_INIT      = 3'd2;
  localparam logic [2:0] CMD_INIT_ECHO = 3'd3;
  localparam logic [2:0] CMD_RECONNECT = 3'd4;
  localparam logic [2:0] CMD_CONNECT   = 3'd5;
  localparam logic [2:0] CMD_RESET     = 3'd6;
  localparam logic [2:0] CMD_RADIO     = 3'd7;

  // Configuration register indexes
  localparam logic [2:0] REG_BOOT_SETTLE   = 3'd0;
  localparam logic [2:0] REG_RESET_SETTLE  = 3'd1;
  localparam logic [2:0] REG_NET_TIMEOUT   = 3'd2;
  localparam logic [2:0] REG_ATT_TIMEOUT   = 3'd3;
  localparam logic [2:0] REG_HEALTH_PERIOD = 3'd4;
  localparam logic [2:0] REG_NET_CHECK     = 3'd5;
  localparam logic [2:0] REG_GOOD_WAIT     = 3'd6;
  localparam logic [2:0] REG_GOOD_MIN      = 3'd7;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 18;

  // Other fixed values
  localparam logic [16:0] PROBE_WINDOW_MS = 17'd20000;
  localparam logic [2:0]  REG_DENIED      = 3'd3;
  localparam logic [6:0]  CSQ_UNKNOWN     = 7'd99;
  localparam logic [6:0]  CSQ_MAX         = 7'd31;
  localparam logic [7:0]  RSSI_BASE       = 8'd143;
  localparam logic [2:0]  FAIL_MAX        = 3'd4;
  localparam logic [7:0]  COUNT_MAX       = 8'd255;

  // Register reset values
  localparam logic [15:0] BOOT_SETTLE_RST   = 16'd5000;
  localparam logic [15:0] RESET_SETTLE_RST  = 16'd3000;
  localparam logic [17:0] NET_TIMEOUT_RST   = 18'd60000;
  localparam logic [17:0] ATT_TIMEOUT_RST   = 18'd25000;
  localparam logic [17:0] HEALTH_PERIOD_RST = 18'd30000;
  localparam logic [15:0] NET_CHECK_RST     = 16'd3000;
  localparam logic [17:0] GOOD_WAIT_RST     = 18'd20000;
  localparam logic [4:0]  GOOD_MIN_RST      = 5'd15;

  typedef struct packed {
    logic [15:0] cold_settle_ms;
    logic [15:0] reset_settle_ms;
    logic [17:0] network_timeout_ms;
    logic [17:0] attach_timeout_ms;
    logic [17:0] health_period_ms;
    logic [15:0] net_check_ms;
    logic [17:0] good_signal_wait_ms;
    logic [4:0]  good_signal_min;
  } cls_cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] now_ms;
    logic        at_ok;
    logic        init_ok;
    logic        net_registered;
    logic [2:0]  reg_status;
    logic [6:0]  signal_quality;
    logic        gprs_up;
    logic [31:0] ip_addr;
    logic        mqtt_up;
  } cls_item_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [31:0] phase_start;
    logic [31:0] last_poll;
    logic [31:0] retry_at;
    logic [31:0] last_health;
    logic [2:0]  fail_count;
    logic        after_reset;
    logic        http_owned;
    logic        paused_by_fail;
    logic        redo_context;
    logic        check_same_ip;
    logic [31:0] previous_ip;
    logic [31:0] activation_count;
    logic [7:0]  transport_streak;
    logic [7:0]  reset_count;
  } cls_state_t;

  typedef struct packed {
    logic [2:0]        link_state;
    logic [2:0]        modem_cmd;
    logic              pause_mqtt;
    logic              resume_mqtt;
    logic              http_granted;
    logic              close_http;
    logic [31:0]       pdp_sequence;
    logic signed [7:0] rssi_dbm;
  } cls_result_t;

  // Retry delay for a failure count index.
  function automatic logic [14:0] retry_wait(input logic [1:0] idx);
    logic [14:0] w;
    unique case (idx)
      2'd0: w = 15'd2000;
      2'd1: w = 15'd5000;
      2'd2: w = 15'd15000;
      2'd3: w = 15'd30000;
      default: w = 15'd30000;
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/cellular_link_supervisor_core.sv @@
// Top level of the cellular link supervisor: stream ports, registers and state.
//
// Usage: each input transfer on the s_axis channel is one tick or event, its
// kind in tuser and the modem's sampled answers in tdata. Every input transfer
// gives exactly one result transfer on the m_axis channel: the link phase after
// the item, the modem command to issue, the MQTT and HTTP flags, the context
// activation count and the signal strength in dBm.
// The result is in the output register at the clock edge after the input
// transfer. One item is taken per cycle while the output register is empty
// or its result is taken; the whole state update is one pass of flat logic
// from the state registers to their next values, so throughput is then one
// item per cycle. Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) take
// effect at the clock edge; the user must make them while no item is in
// flight, which the block does not enforce. Reset (rst, synchronous) sets the
// phase to off, clears all state and the output valid, loads the register
// defaults, and s_axis_tready is low during reset. When the receiver stalls,
// the result is held; a new item is taken in the cycle the result is taken.
module cellular_link_supervisor_core (
  input  logic                                clk,
  input  logic                                rst,
  // Input items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // now_ms[31:0], at_ok[32], init_ok[33], net_registered[34], reg_status[37:35],
  // signal_quality[44:38], gprs_up[45], ip_addr[77:46], mqtt_up[78], zero[79]
  input  logic [79:0]                         s_axis_tdata,
  // mode[2:0]
  input  logic [2:0]                          s_axis_tuser,
  // Results
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // link_state[2:0], modem_cmd[5:3], pause_mqtt[6], resume_mqtt[7],
  // http_granted[8], close_http[9], pdp_sequence[41:10], rssi_dbm[49:42], zero[55:50]
  output logic [55:0]                         m_axis_tdata,
  // Configuration writes
  input  logic                                cfg_wr_en,
  input  logic [cls_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cls_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import cls_pkg::*;

  cls_cfg_t    cfg;
  cls_state_t  st;
  cls_state_t  st_next;
  cls_item_t   item;
  cls_result_t res;
  logic        accept;

  // Handshake: a held result does not block a new item once it is taken.
  assign s_axis_tready = !rst && (!m_axis_tvalid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Unpack the input transfer
  assign item.mode           = s_axis_tuser;
  assign item.now_ms         = s_axis_tdata[31:0];
  assign item.at_ok          = s_axis_tdata[32];
  assign item.init_ok        = s_axis_tdata[33];
  assign item.net_registered = s_axis_tdata[34];
  assign item.reg_status     = s_axis_tdata[37:35];
  assign item.signal_quality = s_axis_tdata[44:38];
  assign item.gprs_up        = s_axis_tdata[45];
  assign item.ip_addr        = s_axis_tdata[77:46];
  assign item.mqtt_up        = s_axis_tdata[78];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cold_settle_ms      <= BOOT_SETTLE_RST;
      cfg.reset_settle_ms     <= RESET_SETTLE_RST;
      cfg.network_timeout_ms  <= NET_TIMEOUT_RST;
      cfg.attach_timeout_ms   <= ATT_TIMEOUT_RST;
      cfg.health_period_ms    <= HEALTH_PERIOD_RST;
      cfg.net_check_ms        <= NET_CHECK_RST;
      cfg.good_signal_wait_ms <= GOOD_WAIT_RST;
      cfg.good_signal_min     <= GOOD_MIN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BOOT_SETTLE:   cfg.cold_settle_ms      <= cfg_wdata[15:0];
        REG_RESET_SETTLE:  cfg.reset_settle_ms     <= cfg_wdata[15:0];
        REG_NET_TIMEOUT:   cfg.network_timeout_ms  <= cfg_wdata;
        REG_ATT_TIMEOUT:   cfg.attach_timeout_ms   <= cfg_wdata;
        REG_HEALTH_PERIOD: cfg.health_period_ms    <= cfg_wdata;
        REG_NET_CHECK:     cfg.net_check_ms        <= cfg_wdata[15:0];
        REG_GOOD_WAIT:     cfg.good_signal_wait_ms <= cfg_wdata;
        REG_GOOD_MIN:      cfg.good_signal_min     <= cfg_wdata[4:0];
        default: begin
        end
      endcase
    end
  end

  cls_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (item),
    .st_next (st_next),
    .res     (res)
  );

  // Supervisor state advances on every input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      // The off phase has code zero, so clearing the state also selects it.
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {6'd0, res.rssi_dbm, res.pdp_sequence, res.close_http,
                       res.http_granted, res.resume_mqtt, res.pause_mqtt,
                       res.modem_cmd, res.link_state};
    end
  end

  // A transfer in always leaves a result waiting in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("accepted item left no result");

  // The reported phase is the phase the state register moved to.
  a_phase_matches: assert property (@(posedge clk) disable iff (rst)
    $past(accept && !rst) |-> m_axis_tdata[2:0] == st.phase)
    else $error("result phase differs from state");

  // The failure count saturates at its ceiling.
  a_fail_sat: assert property (@(posedge clk) disable iff (rst)
    st.fail_count <= FAIL_MAX)
    else $error("failure count above ceiling");

  // The activation count only moves on an input transfer.
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(st.activation_count))
    else $error("activation count moved without an item");

  // An empty output register never holds off the input side.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

endmodule

@@ hw/rtl/cls_step.sv @@
// Next-state and result logic for one supervisor item.
module cls_step (
  input  cls_pkg::cls_cfg_t    cfg,
  input  cls_pkg::cls_state_t  st,
  input  cls_pkg::cls_item_t   item,
  output cls_pkg::cls_state_t  st_next,
  output cls_pkg::cls_result_t res
);
  import cls_pkg::*;

  // Retry wait: pause the session and arm the backoff timer.
  function automatic cls_state_t enter_backoff(input cls_state_t s, input logic [31:0] now);
    cls_state_t r;
    logic [1:0] idx;
    r = s;
    idx = (s.fail_count < FAIL_MAX) ? s.fail_count[1:0] : 2'd3;
    if (s.fail_count < FAIL_MAX) begin
      r.fail_count = s.fail_count + 3'd1;
    end
    r.paused_by_fail = 1'b1;
    r.http_owned = 1'b0;
    r.phase = PH_BACKOFF;
    r.retry_at = now + {17'd0, retry_wait(idx)};
    return r;
  endfunction

  // Modem reset: clears recovery flags and goes back to settling.
  function automatic cls_state_t reset_modem(input cls_state_t s, input logic [31:0] now);
    cls_state_t r;
    r = s;
    r.paused_by_fail = 1'b1;
    r.http_owned = 1'b0;
    r.transport_streak = 8'd0;
    r.redo_context = 1'b0;
    r.check_same_ip = 1'b0;
    if (s.reset_count < COUNT_MAX) begin
      r.reset_count = s.reset_count + 8'd1;
    end
    r.after_reset = 1'b1;
    r.phase = PH_SETTLING;
    r.phase_start = now;
    return r;
  endfunction

  logic [31:0] now;
  logic [31:0] elapsed;
  logic [31:0] since_poll;
  logic [31:0] since_health;
  logic [15:0] settle;
  logic [16:0] settle_limit;
  logic        good;
  logic [2:0]  reset_cmd;
  logic [7:0]  streak_inc;
  logic        ready_free;

  assign now          = item.now_ms;
  assign elapsed      = now - st.phase_start;
  assign since_poll   = now - st.last_poll;
  assign since_health = now - st.last_health;
  assign settle       = st.after_reset ? cfg.reset_settle_ms : cfg.cold_settle_ms;
  assign settle_limit = {1'b0, settle} + PROBE_WINDOW_MS;
  assign good         = (item.signal_quality >= {2'b00, cfg.good_signal_min}) &&
                        (item.signal_quality != CSQ_UNKNOWN);
  assign reset_cmd    = st.reset_count[0] ? CMD_RADIO : CMD_RESET;
  assign streak_inc   = (st.transport_streak < COUNT_MAX) ? st.transport_streak + 8'd1
                                                           : st.transport_streak;
  assign ready_free   = (st.phase == PH_READY) && !st.http_owned;

  // Item decode and state update
  always_comb begin
    st_next = st;
    res = '0;
    unique case (item.mode)
      MODE_TICK: begin
        unique case (st.phase)
          PH_SETTLING: begin
            if (elapsed >= {16'd0, settle}) begin
              if (elapsed > {15'd0, settle_limit}) begin
                st_next = enter_backoff(st, now);
                res.pause_mqtt = 1'b1;
              end else begin
                res.modem_cmd = CMD_PROBE;
                if (item.at_ok) begin
                  st_next.phase = PH_INIT;
                  st_next.phase_start = now;
                end
              end
            end
          end
          PH_INIT: begin
            res.modem_cmd = item.init_ok ? CMD_INIT : CMD_INIT_ECHO;
            st_next.phase = PH_NETWORK;
            st_next.phase_start = now;
            st_next.last_poll = now;
          end
          PH_NETWORK: begin
            if (item.net_registered) begin
              st_next.phase = PH_ATTACHING;
              st_next.phase_start = now;
            end else if (since_poll >= {16'd0, cfg.net_check_ms}) begin
              st_next.last_poll = now;
              if ((item.reg_status == REG_DENIED) ||
                  (good && elapsed >= {14'd0, cfg.good_signal_wait_ms}) ||
                  (elapsed > {14'd0, cfg.network_timeout_ms})) begin
                st_next = reset_modem(st, now);
                res.pause_mqtt = 1'b1;
                res.modem_cmd = reset_cmd;
              end
            end
          end
          PH_ATTACHING: begin
            if (st.redo_context) begin
              st_next.redo_context = 1'b0;
              st_next.check_same_ip = 1'b1;
              st_next.phase_start = now;
              res.modem_cmd = CMD_RECONNECT;
            end else if (item.gprs_up) begin
              if (st.check_same_ip && item.ip_addr != 32'd0 &&
                  item.ip_addr == st.previous_ip) begin
                // Same address after a rebuild: the context did not really renew.
                st_next = reset_modem(st, now);
                res.pause_mqtt = 1'b1;
                res.modem_cmd = reset_cmd;
              end else begin
                st_next.check_same_ip = 1'b0;
                st_next.previous_ip = item.ip_addr;
                st_next.activation_count = st.activation_count + 32'd1;
                st_next.fail_count = 3'd0;
                st_next.phase = PH_READY;
                st_next.last_health = now;
                if (st.paused_by_fail) begin
                  st_next.paused_by_fail = 1'b0;
                  res.resume_mqtt = 1'b1;
                end
              end
            end else if (elapsed > {14'd0, cfg.attach_timeout_ms}) begin
              st_next = reset_modem(st, now);
              res.pause_mqtt = 1'b1;
              res.modem_cmd = reset_cmd;
            end else begin
              res.modem_cmd = CMD_CONNECT;
            end
          end
          PH_READY: begin
            if (!st.http_owned && !item.mqtt_up &&
                since_health >= {14'd0, cfg.health_period_ms}) begin
              st_next.last_health = now;
              if (!item.gprs_up) begin
                st_next.redo_context = 1'b1;
                st_next = enter_backoff(st_next, now);
                res.pause_mqtt = 1'b1;
              end
            end
          end
          PH_BACKOFF: begin
            if (now >= st.retry_at) begin
              st_next.phase = PH_INIT;
              st_next.phase_start = now;
            end
          end
          default: begin
          end
        endcase
      end
      MODE_START: begin
        st_next.phase = PH_SETTLING;
        st_next.phase_start = now;
      end
      MODE_XPORT: begin
        if (ready_free) begin
          st_next.transport_streak = streak_inc;
          if (streak_inc >= 8'd2) begin
            st_next = reset_modem(st_next, now);
            res.modem_cmd = reset_cmd;
          end else begin
            st_next.redo_context = 1'b1;
            st_next = enter_backoff(st_next, now);
          end
          res.pause_mqtt = 1'b1;
        end
      end
      MODE_LOST: begin
        if (ready_free) begin
          if (st.transport_streak == 8'd0) begin
            st_next.transport_streak = 8'd1;
          end
          st_next.redo_context = 1'b1;
          st_next = enter_backoff(st_next, now);
          res.pause_mqtt = 1'b1;
        end
      end
      MODE_CONNECTED: begin
        st_next.transport_streak = 8'd0;
        st_next.reset_count = 8'd0;
      end
      MODE_ACQUIRE: begin
        if (ready_free) begin
          st_next.http_owned = 1'b1;
          res.pause_mqtt = 1'b1;
          res.http_granted = 1'b1;
        end
      end
      MODE_RELEASE: begin
        if (st.http_owned) begin
          st_next.http_owned = 1'b0;
          res.close_http = 1'b1;
          res.resume_mqtt = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.link_state = st_next.phase;
    res.pdp_sequence = st_next.activation_count;
    // Signal strength: -113 dBm plus 2 dB per step, zero above 31 (so also when unknown).
    res.rssi_dbm = (item.signal_quality > CSQ_MAX) ? 8'sd0 :
                   $signed(RSSI_BASE + {2'b00, item.signal_quality[4:0], 1'b0});
  end

endmodule
